/* design/bme_pkg.sv */
package bme_pkg;

	typedef enum logic [1:0] {
		REG_STEP_TIME     = 2'd0,
		REG_INV_WHEELBASE = 2'd1,
		REG_MAX_STEER     = 2'd2
	} cfg_reg_t;

	localparam logic [16:0] STEP_TIME_RST  = 17'd3277;
	localparam logic [20:0] INV_WB_RST     = 21'd23406;
	localparam logic [16:0] MAX_STEER_RST  = 17'd32768;

	localparam logic [29:0] INV_TWO_PI_Q32 = 30'd683565276;
	localparam logic [30:0] HALF_PI_Q30    = 31'd1686629713;
	localparam logic [30:0] ONE_Q30        = 31'h4000_0000;

	localparam int COS_DIV [5] = '{90, 56, 30, 12, 2};
	localparam int SIN_DIV [4] = '{72, 42, 20, 6};

	localparam logic signed [31:0] STEER_ONE = 32'sd65536;
	localparam logic [24:0] TAN_LIMIT = 25'h100_0000;

	function automatic logic [32:0] sat32(input logic signed [63:0] v);
		logic [32:0] r;
		if (v > 64'sd2147483647) begin
			r = {1'b1, 32'h7FFF_FFFF};
		end else if (v < -64'sd2147483648) begin
			r = {1'b1, 32'h8000_0000};
		end else begin
			r = {1'b0, v[31:0]};
		end
		return r;
	endfunction

endpackage

/* design/bme_sincos.sv */
module bme_sincos import bme_pkg::*; (
	input  logic               clk,
	input  logic               en,
	input  logic [31:0]        phase,
	output logic signed [31:0] sin_val,
	output logic signed [31:0] cos_val
);

	typedef enum logic [1:0] {QUAD0, QUAD1, QUAD2, QUAD3} quad_t;

	logic [1:0]  qd_s [1:18];
	logic [60:0] thp_s1;
	logic [30:0] theta;
	logic [30:0] th_s [2:15];
	logic [61:0] sq_s2;
	logic [31:0] x2_s [3:15];
	logic [30:0] ct [0:4];
	logic [30:0] st [0:3];
	logic [61:0] sp_s16;
	logic [31:0] sn_s17;
	logic [31:0] sn_s18;
	logic signed [31:0] sn;
	logic signed [31:0] cs;
	logic signed [31:0] sin_nx;
	logic signed [31:0] cos_nx;

	assign theta = thp_s1[60:30];

	always_ff @(posedge clk) begin
		if (en) begin
			qd_s[1] <= phase[31:30];
			for (int i = 2; i <= 18; i++) qd_s[i] <= qd_s[i-1];
			thp_s1 <= 61'(phase[29:0]) * 61'(HALF_PI_Q30);
			th_s[2] <= theta;
			for (int i = 3; i <= 15; i++) th_s[i] <= th_s[i-1];
			sq_s2 <= 62'(theta) * 62'(theta);
			x2_s[3] <= sq_s2[61:30];
			for (int i = 4; i <= 15; i++) x2_s[i] <= x2_s[i-1];
		end
	end

	// Each Horner step takes three stages: square times term, divide by a
	// reciprocal multiply, then subtract from one and clamp at zero.
	for (genvar j = 0; j < 5; j++) begin : g_cos
		localparam int unsigned K = COS_DIV[j];
		localparam int unsigned SH = 32 + $clog2(K);
		localparam logic [32:0] MUL = 33'(((65'd1 << SH) + 65'(K) - 65'd1) / 65'(K));
		logic [62:0] ma_s;
		logic [64:0] mb_s;
		logic [30:0] t_s;
		logic [30:0] t_in;
		logic signed [33:0] u;
		if (j == 0) begin : g_one
			assign t_in = ONE_Q30;
		end else begin : g_chain
			assign t_in = ct[j-1];
		end
		assign u = 34'sh4000_0000 - $signed({2'b00, 32'(mb_s >> SH)});
		always_ff @(posedge clk) begin
			if (en) begin
				ma_s <= 63'(x2_s[3*j+3]) * 63'(t_in);
				mb_s <= 65'(ma_s[61:30]) * 65'(MUL);
				t_s  <= u[33] ? '0 : u[30:0];
			end
		end
		assign ct[j] = t_s;
	end

	for (genvar j = 0; j < 4; j++) begin : g_sin
		localparam int unsigned K = SIN_DIV[j];
		localparam int unsigned SH = 32 + $clog2(K);
		localparam logic [32:0] MUL = 33'(((65'd1 << SH) + 65'(K) - 65'd1) / 65'(K));
		logic [62:0] ma_s;
		logic [64:0] mb_s;
		logic [30:0] t_s;
		logic [30:0] t_in;
		logic signed [33:0] u;
		if (j == 0) begin : g_one
			assign t_in = ONE_Q30;
		end else begin : g_chain
			assign t_in = st[j-1];
		end
		assign u = 34'sh4000_0000 - $signed({2'b00, 32'(mb_s >> SH)});
		always_ff @(posedge clk) begin
			if (en) begin
				ma_s <= 63'(x2_s[3*j+3]) * 63'(t_in);
				mb_s <= 65'(ma_s[61:30]) * 65'(MUL);
				t_s  <= u[33] ? '0 : u[30:0];
			end
		end
		assign st[j] = t_s;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sp_s16 <= 62'(th_s[15]) * 62'(st[3]);
			sn_s17 <= sp_s16[61:30];
			sn_s18 <= sn_s17;
			sin_val <= sin_nx;
			cos_val <= cos_nx;
		end
	end

	assign sn = $signed(sn_s18);
	assign cs = $signed({1'b0, ct[4]});

	always_comb begin
		case (quad_t'(qd_s[18]))
			QUAD0: begin
				sin_nx = sn;
				cos_nx = cs;
			end
			QUAD1: begin
				sin_nx = cs;
				cos_nx = -sn;
			end
			QUAD2: begin
				sin_nx = -sn;
				cos_nx = -cs;
			end
			QUAD3: begin
				sin_nx = -cs;
				cos_nx = sn;
			end
			default: begin
				sin_nx = sn;
				cos_nx = cs;
			end
		endcase
	end

endmodule

/* design/bicycle_model_euler_step.sv */
// One forward-Euler step of the kinematic bicycle model in Q16.16.
// The input stream carries one vehicle state and control pair per transaction;
// the output stream returns the next state and a saturation flag.
// Step time, inverse wheelbase and maximum steering angle are set through the
// write port; the user must write them only while the pipeline is empty, which
// the block itself does not enforce; reset loads their default values. The
// pipeline has 55 register stages. Throughput is one transaction per cycle
// while the receiver does not stall: the pipeline is fully staged. The
// steering path runs through a 19-stage sine/cosine unit and then a 25-stage
// restoring divider for the tangent, one quotient bit per stage; the heading
// sine/cosine unit, also 19 stages, runs beside the divider.
// When the receiver stalls a valid result, all stages hold and the input side
// deasserts tready; nothing is dropped or repeated.
// Reset clears all valid bits, so no result appears until new input arrives.
module bicycle_model_euler_step import bme_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// pos_x, pos_y, heading, speed, steer_cmd, accel
	input  logic [191:0] s_axis_tdata,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// next_x, next_y, next_heading, next_speed
	output logic [127:0] m_axis_tdata,
	// overflow
	output logic [0:0]   m_axis_tuser,
	input  logic         cfg_we,
	input  logic [1:0]   cfg_index,
	input  logic [20:0]  cfg_data
);

	localparam int LAT = 55;

	logic [16:0] dt_q;
	logic [20:0] invl_q;
	logic [16:0] maxang_q;
	logic        vld_s [1:LAT];
	logic        en;

	logic signed [31:0] pos_x, pos_y, heading, speed, steer_cmd, accel;
	logic signed [31:0] x_s [1:54];
	logic signed [31:0] y_s [1:54];
	logic signed [31:0] yaw_s [1:54];
	logic signed [31:0] v_s [1:54];
	logic signed [31:0] acc_s [1:54];
	logic signed [17:0] steer_c_s1;
	logic signed [35:0] dprod_s2;
	logic signed [19:0] delta_s3;
	logic signed [50:0] dp_s4;
	logic signed [62:0] yp_s31;
	logic signed [31:0] d_sin, d_cos, y_sin, y_cos;

	logic [31:0] sd_mag, cd_mag;
	logic [47:0] dr_s [24:49];
	logic [31:0] dd_s [24:49];
	logic [24:0] dq_s [24:49];
	logic        dneg_s [24:49];
	logic        dovr_s [24:49];
	logic [56:0] dsh [25:49];
	logic        dfit [25:49];
	logic [24:0] tmag;
	logic signed [25:0] tn_s50;

	logic signed [53:0] pwl_s49;
	logic signed [39:0] w_s50;
	logic signed [63:0] pxc_s51, pys_s51;
	logic signed [65:0] pw_s51;
	logic signed [49:0] pa_s51;
	logic signed [33:0] dx_s52, dy_s52;
	logic signed [49:0] dyaw_s52;
	logic signed [35:0] ra_s52, ra_s53, ra_s54;
	logic signed [51:0] mx_s53, my_s53;
	logic signed [67:0] mh_s53;
	logic signed [37:0] rx_s54, ry_s54;
	logic signed [53:0] rh_s54;
	logic [32:0] sx, sy, sh, sv;
	logic [31:0] next_x_s55, next_y_s55, next_heading_s55, next_speed_s55;
	logic        ovf_s55;

	assign pos_x      = s_axis_tdata[31:0];
	assign pos_y      = s_axis_tdata[63:32];
	assign heading    = s_axis_tdata[95:64];
	assign speed      = s_axis_tdata[127:96];
	assign steer_cmd  = s_axis_tdata[159:128];
	assign accel      = s_axis_tdata[191:160];

	assign en = !vld_s[LAT] || m_axis_tready;
	assign s_axis_tready = en;
	assign m_axis_tvalid = vld_s[LAT];
	assign m_axis_tdata = {next_speed_s55, next_heading_s55, next_y_s55, next_x_s55};
	assign m_axis_tuser = ovf_s55;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dt_q     <= STEP_TIME_RST;
			invl_q   <= INV_WB_RST;
			maxang_q <= MAX_STEER_RST;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_STEP_TIME:     dt_q     <= cfg_data[16:0];
				REG_INV_WHEELBASE: invl_q   <= cfg_data;
				REG_MAX_STEER:     maxang_q <= cfg_data[16:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 1; i <= LAT; i++) vld_s[i] <= 1'b0;
		end else if (en) begin
			vld_s[1] <= s_axis_tvalid;
			for (int i = 2; i <= LAT; i++) vld_s[i] <= vld_s[i-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s[1]   <= pos_x;
			y_s[1]   <= pos_y;
			yaw_s[1] <= heading;
			v_s[1]   <= speed;
			acc_s[1] <= accel;
			for (int i = 2; i <= 54; i++) begin
				x_s[i]   <= x_s[i-1];
				y_s[i]   <= y_s[i-1];
				yaw_s[i] <= yaw_s[i-1];
				v_s[i]   <= v_s[i-1];
				acc_s[i] <= acc_s[i-1];
			end
			if (steer_cmd > STEER_ONE) begin
				steer_c_s1 <= 18'(STEER_ONE);
			end else if (steer_cmd < -STEER_ONE) begin
				steer_c_s1 <= 18'(-STEER_ONE);
			end else begin
				steer_c_s1 <= steer_cmd[17:0];
			end
			dprod_s2 <= steer_c_s1 * $signed({1'b0, maxang_q});
			delta_s3 <= 20'((dprod_s2 + 36'sd32768) >>> 16);
			dp_s4    <= delta_s3 * $signed({1'b0, INV_TWO_PI_Q32});
			yp_s31   <= yaw_s[30] * $signed({1'b0, INV_TWO_PI_Q32});
		end
	end

	bme_sincos u_sc_delta (
		.clk     (clk),
		.en      (en),
		.phase   (dp_s4[47:16]),
		.sin_val (d_sin),
		.cos_val (d_cos)
	);

	bme_sincos u_sc_yaw (
		.clk     (clk),
		.en      (en),
		.phase   (yp_s31[47:16]),
		.sin_val (y_sin),
		.cos_val (y_cos)
	);

	assign sd_mag = d_sin[31] ? 32'(-d_sin) : d_sin;
	assign cd_mag = d_cos[31] ? 32'(-d_cos) : d_cos;

	always_comb begin
		for (int i = 25; i <= 49; i++) begin
			dsh[i]  = 57'(dd_s[i-1]) << (49 - i);
			dfit[i] = {9'b0, dr_s[i-1]} >= dsh[i];
		end
	end

	// The tangent quotient is formed on magnitudes, one bit per stage.
	always_ff @(posedge clk) begin
		if (en) begin
			dr_s[24]   <= {sd_mag, 16'b0};
			dd_s[24]   <= cd_mag;
			dq_s[24]   <= '0;
			dneg_s[24] <= (d_cos == '0) ? d_sin[31] : (d_sin[31] ^ d_cos[31]);
			dovr_s[24] <= {9'b0, sd_mag, 16'b0} >= {cd_mag, 25'b0};
			for (int i = 25; i <= 49; i++) begin
				dr_s[i]   <= dfit[i] ? dr_s[i-1] - dsh[i][47:0] : dr_s[i-1];
				dq_s[i]   <= dq_s[i-1] | (dfit[i] ? (25'd1 << (49 - i)) : 25'd0);
				dd_s[i]   <= dd_s[i-1];
				dneg_s[i] <= dneg_s[i-1];
				dovr_s[i] <= dovr_s[i-1];
			end
		end
	end

	assign tmag = (dovr_s[49] || dq_s[49] > TAN_LIMIT) ? TAN_LIMIT : dq_s[49];

	assign sx = sat32(64'(x_s[54]) + 64'(rx_s54));
	assign sy = sat32(64'(y_s[54]) + 64'(ry_s54));
	assign sh = sat32(64'(yaw_s[54]) + 64'(rh_s54));
	assign sv = sat32(64'(v_s[54]) + 64'(ra_s54));

	always_ff @(posedge clk) begin
		if (en) begin
			pwl_s49 <= v_s[48] * $signed({1'b0, invl_q});
			w_s50   <= 40'((pwl_s49 + 54'sd32768) >>> 16);
			tn_s50  <= dneg_s[49] ? -$signed({1'b0, tmag}) : $signed({1'b0, tmag});

			pxc_s51 <= v_s[50] * y_cos;
			pys_s51 <= v_s[50] * y_sin;
			pw_s51  <= w_s50 * tn_s50;
			pa_s51  <= $signed({1'b0, dt_q}) * acc_s[50];

			dx_s52   <= 34'((pxc_s51 + 64'sd536870912) >>> 30);
			dy_s52   <= 34'((pys_s51 + 64'sd536870912) >>> 30);
			dyaw_s52 <= 50'((pw_s51 + 66'sd32768) >>> 16);
			ra_s52   <= 36'((pa_s51 + 50'sd32768) >>> 16);

			mx_s53 <= $signed({1'b0, dt_q}) * dx_s52;
			my_s53 <= $signed({1'b0, dt_q}) * dy_s52;
			mh_s53 <= $signed({1'b0, dt_q}) * dyaw_s52;
			ra_s53 <= ra_s52;

			rx_s54 <= 38'((mx_s53 + 52'sd32768) >>> 16);
			ry_s54 <= 38'((my_s53 + 52'sd32768) >>> 16);
			rh_s54 <= 54'((mh_s53 + 68'sd32768) >>> 16);
			ra_s54 <= ra_s53;

			next_x_s55       <= sx[31:0];
			next_y_s55       <= sy[31:0];
			next_heading_s55 <= sh[31:0];
			next_speed_s55   <= sv[31:0];
			ovf_s55          <= sx[32] | sy[32] | sh[32] | sv[32];
		end
	end

endmodule

/* design/bme_chk.sv */
module bme_chk (
	input logic         clk,
	input logic         arst_n,
	input logic         s_axis_tvalid,
	input logic         s_axis_tready,
	input logic         m_axis_tvalid,
	input logic         m_axis_tready,
	input logic [127:0] m_axis_tdata,
	input logic [0:0]   m_axis_tuser
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("Stalled output transaction changed.");

	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready == (!m_axis_tvalid || m_axis_tready))
		else $error("Input ready does not follow the output stall.");

	a_reset_empty: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> !m_axis_tvalid)
		else $error("Output valid right after reset.");

	a_ovf_sat: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[0] |->
			m_axis_tdata[31:0] == 32'h7FFF_FFFF || m_axis_tdata[31:0] == 32'h8000_0000 ||
			m_axis_tdata[63:32] == 32'h7FFF_FFFF || m_axis_tdata[63:32] == 32'h8000_0000 ||
			m_axis_tdata[95:64] == 32'h7FFF_FFFF || m_axis_tdata[95:64] == 32'h8000_0000 ||
			m_axis_tdata[127:96] == 32'h7FFF_FFFF || m_axis_tdata[127:96] == 32'h8000_0000)
		else $error("Overflow flagged without a saturated field.");

endmodule

bind bicycle_model_euler_step bme_chk u_bme_chk (.*);
